[src/sptlm_pkg.sv]
package sptlm_pkg;

    localparam int PRIMARY_HEADER_BYTES = 6;
    localparam int TIME_HEADER_BYTES = 6;
    localparam int LENGTH_FIELD_OFFSET = 4;
    localparam logic [7:0] TYPE_BIT = 8'h10;
    localparam logic [7:0] SECHDR_BIT = 8'h08;

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_FETCH = 1'b1
    } cmd_t;

    typedef struct packed {
        logic        command;
        logic [7:0]  in_byte;
        logic        in_last;
        logic [31:0] time_seconds;
        logic [19:0] time_micros;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        logic       out_last;
        logic       malformed;
        logic       overflowed;
    } out_item_t;

    // Queue entry handed from the front part to the back part.
    typedef struct packed {
        logic        command;
        logic [7:0]  in_byte;
        logic        in_last;
        logic [31:0] time_seconds;
        logic [15:0] subseconds;
    } job_t;

endpackage

[src/sptlm_if.sv]
interface sptlm_in_if;
    import sptlm_pkg::*;
    logic     valid;
    logic     ready;
    in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface sptlm_out_if;
    import sptlm_pkg::*;
    logic      valid;
    logic      ready;
    out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[src/space_packet_tlm_header_inserter.sv]
// CCSDS space packet time header inserter. Load transactions (command 0)
// write one byte each into a BUFFER_BYTES store while a parser checks the
// packet tiling; the byte with in_last set completes the buffer and latches
// the time. Fetch transactions (command 1) each return one result: the next
// output byte, with a six-byte time header inserted after the primary header
// of every telemetry packet lacking a secondary header. In the back end a
// fetch that returns a byte is done as a store read, then byte formation,
// with a further step on the first length byte of a packet, where the low
// length byte is read from the store for the carry. A load, and a fetch
// with nothing to return, complete as they are accepted. While a result
// waits to be taken the back end accepts nothing; the front end, which
// scales the microseconds, and a two-entry queue ahead of the back end
// then absorb up to three more transactions before the input stalls.
module space_packet_tlm_header_inserter #(
    parameter int BUFFER_BYTES = 2048
) (
    input  logic        clk,
    input  logic        rst_n,
    sptlm_in_if.sink    in_ch,
    sptlm_out_if.source out_ch
);
    import sptlm_pkg::*;

    logic fq_valid;
    logic fq_ready;
    job_t fq_job;
    logic qb_valid;
    logic qb_ready;
    job_t qb_job;

    sptlm_front u_front (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
        .job_valid(fq_valid), .job(fq_job), .job_ready(fq_ready)
    );

    sptlm_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(fq_valid), .wr_data(fq_job), .wr_ready(fq_ready),
        .rd_valid(qb_valid), .rd_data(qb_job), .rd_ready(qb_ready)
    );

    sptlm_back #(.BUFFER_BYTES(BUFFER_BYTES)) u_back (
        .clk(clk), .rst_n(rst_n),
        .job_valid(qb_valid), .job(qb_job), .job_ready(qb_ready),
        .out_ch(out_ch)
    );
endmodule

[src/sptlm_front.sv]
// Accepts transactions and converts the microseconds to 1/65536 s units.
// micros*65536/1e6 = micros*4096/62500: a multiply by a 17-bit reciprocal
// gives an estimate low by at most one, fixed with one compare. The multiply
// is done as the transaction is accepted and the fix follows from the register.
module sptlm_front (
    input  logic                clk,
    input  logic                rst_n,
    sptlm_in_if.sink            in_ch,
    output logic                job_valid,
    output sptlm_pkg::job_t     job,
    input  logic                job_ready
);
    import sptlm_pkg::*;

    localparam logic [16:0] RECIP = 17'd68719;  // floor(2^32/62500)

    logic        s1_valid_reg;
    in_item_t    s1_reg;
    logic [16:0] quot_reg;
    logic [48:0] prod;
    logic [31:0] num;
    logic [31:0] quot;
    logic [31:0] rem;
    logic [31:0] q_fix;

    assign in_ch.ready = !s1_valid_reg || job_ready;
    assign prod = 49'({in_ch.data.time_micros, 12'd0}) * 49'(RECIP);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
        end else if (in_ch.ready) begin
            s1_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk) begin
        if (in_ch.ready && in_ch.valid) begin
            s1_reg <= in_ch.data;
            quot_reg <= prod[48:32];
        end
    end

    always_comb begin
        num = {s1_reg.time_micros, 12'd0};
        quot = 32'(quot_reg);
        rem = num - 32'(quot * 32'd62500);
        q_fix = (rem >= 32'd62500) ? quot + 32'd1 : quot;
    end

    assign job_valid = s1_valid_reg;
    assign job.command = s1_reg.command;
    assign job.in_byte = s1_reg.in_byte;
    assign job.in_last = s1_reg.in_last;
    assign job.time_seconds = s1_reg.time_seconds;
    assign job.subseconds = q_fix[15:0];
endmodule

[src/sptlm_queue.sv]
// Two-entry queue between front and back.
module sptlm_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_valid,
    input  sptlm_pkg::job_t wr_data,
    output logic            wr_ready,
    output logic            rd_valid,
    output sptlm_pkg::job_t rd_data,
    input  logic            rd_ready
);
    import sptlm_pkg::*;

    job_t       mem_reg [2];
    logic       wp_reg;
    logic       rp_reg;
    logic [1:0] cnt_reg;

    assign wr_ready = cnt_reg != 2'd2;
    assign rd_valid = cnt_reg != 2'd0;
    assign rd_data = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (wr_valid && wr_ready) begin
                wp_reg <= ~wp_reg;
            end
            if (rd_valid && rd_ready) begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + 2'(wr_valid && wr_ready) - 2'(rd_valid && rd_ready);
        end
    end

    always_ff @(posedge clk) begin
        if (wr_valid && wr_ready) begin
            mem_reg[wp_reg] <= wr_data;
        end
    end
endmodule

[src/sptlm_back.sv]
// Executes loads and fetches on the byte store. A fetch reads the store into
// rd_reg, then forms the output byte, the low length byte being read between
// on the first length byte; the read address is known one step ahead. The
// length field is two consecutive bytes, high byte kept from the last fetch.
module sptlm_back #(
    parameter int BUFFER_BYTES = 2048
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            job_valid,
    input  sptlm_pkg::job_t job,
    output logic            job_ready,
    sptlm_out_if.source     out_ch
);
    import sptlm_pkg::*;

    localparam int AW = $clog2(BUFFER_BYTES);
    localparam int CW = $clog2(BUFFER_BYTES + 1);

    logic [7:0]    store [BUFFER_BYTES];
    logic [CW-1:0] load_count_reg;
    logic [15:0]   load_pos_reg;
    logic [16:0]   load_len_reg;
    logic [7:0]    prev_byte_reg;
    logic          well_formed_reg;
    logic          overflow_reg;
    logic          complete_reg;
    logic [31:0]   secs_reg;
    logic [15:0]   subs_reg;
    logic [CW-1:0] rp_reg;
    logic [16:0]   epos_reg;
    logic [16:0]   elen_reg;
    logic          eins_reg;
    logic [7:0]    hi_reg;

    // Fetch phase 2 state
    logic          ph2_reg;
    logic [7:0]    rd_reg;
    logic          outv_reg;
    out_item_t     out_reg;

    // The low length byte is needed for the carry into the high byte; it is
    // the next entry, read in the cycle after the high byte.
    logic [7:0]    store_next_lo;
    logic          lo_phase_reg;
    logic [7:0]    lo_reg;

    logic          busy;
    logic          fetch_go;
    logic          have_byte;
    logic          lo_step;
    logic          ph2_done;

    logic [16:0]   p;
    logic [16:0]   ins;
    logic          ins_f;
    logic [7:0]    ob;
    logic [15:0]   tok;
    logic          adv;
    logic [16:0]   p_n;
    logic [3:0]    k;

    assign busy = ph2_reg || (outv_reg && !out_ch.ready);
    assign job_ready = !busy;
    assign out_ch.valid = outv_reg;
    assign out_ch.data = out_reg;
    assign fetch_go = job_valid && job_ready && job.command == CMD_FETCH;
    assign have_byte = complete_reg && rp_reg < load_count_reg;
    assign store_next_lo = lo_reg;
    assign lo_step = ph2_reg && well_formed_reg && epos_reg == 17'(LENGTH_FIELD_OFFSET)
                     && !lo_phase_reg;
    assign ph2_done = ph2_reg && !lo_step;

    always_ff @(posedge clk) begin
        if (job_valid && job_ready && job.command == CMD_LOAD
            && (complete_reg || load_count_reg < CW'(BUFFER_BYTES))) begin
            store[complete_reg ? AW'(0) : load_count_reg[AW-1:0]] <= job.in_byte;
        end
        if (fetch_go) begin
            rd_reg <= store[rp_reg[AW-1:0]];
        end
    end

    always_comb begin
        p = epos_reg;
        ins_f = eins_reg;
        ob = rd_reg;
        adv = 1'b1;
        tok = {hi_reg, rd_reg};
        k = 4'(p - 17'(PRIMARY_HEADER_BYTES));
        if (p == 17'd0) begin
            ins_f = (rd_reg & (TYPE_BIT | SECHDR_BIT)) == 8'd0;
            ob = ins_f ? (rd_reg | SECHDR_BIT) : rd_reg;
        end
        ins = ins_f ? 17'(TIME_HEADER_BYTES) : 17'd0;
        if (p == 17'(LENGTH_FIELD_OFFSET)) begin
            ob = rd_reg + ((17'({8'd0, store_next_lo}) + ins) > 17'd255 ? 8'd1 : 8'd0);
        end else if (p == 17'(LENGTH_FIELD_OFFSET + 1)) begin
            ob = 8'(16'(tok + 16'(ins)));
        end else if (ins_f && p >= 17'(PRIMARY_HEADER_BYTES)
                     && p < 17'(PRIMARY_HEADER_BYTES + TIME_HEADER_BYTES)) begin
            adv = 1'b0;
            case (k)
                4'd0: ob = secs_reg[31:24];
                4'd1: ob = secs_reg[23:16];
                4'd2: ob = secs_reg[15:8];
                4'd3: ob = secs_reg[7:0];
                4'd4: ob = subs_reg[15:8];
                default: ob = subs_reg[7:0];
            endcase
        end
        p_n = p + 17'd1;
        if (p_n >= 17'(PRIMARY_HEADER_BYTES)
            && p_n == ((p == 17'(LENGTH_FIELD_OFFSET)
                        ? 17'(PRIMARY_HEADER_BYTES) + {1'b0, rd_reg, store_next_lo} + 17'd1
                        : elen_reg) + ins)) begin
            p_n = 17'd0;
        end
    end

    always_ff @(posedge clk) begin
        if (lo_step) begin
            lo_reg <= store[AW'(rp_reg + CW'(1))];
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            load_count_reg <= '0;
            load_pos_reg <= '0;
            load_len_reg <= '0;
            well_formed_reg <= 1'b1;
            overflow_reg <= 1'b0;
            complete_reg <= 1'b0;
            secs_reg <= '0;
            subs_reg <= '0;
            rp_reg <= '0;
            epos_reg <= '0;
            elen_reg <= '0;
            eins_reg <= 1'b0;
            hi_reg <= '0;
            prev_byte_reg <= '0;
            ph2_reg <= 1'b0;
            lo_phase_reg <= 1'b0;
            outv_reg <= 1'b0;
            out_reg <= '0;
        end else begin
            outv_reg <= (outv_reg && !out_ch.ready) || (fetch_go && !have_byte) || ph2_done;
            if (job_valid && job_ready && job.command == CMD_LOAD) begin
                logic [CW-1:0] lc;
                logic [15:0]   lp;
                logic [16:0]   ll;
                logic          wf;
                lc = complete_reg ? '0 : load_count_reg;
                lp = complete_reg ? '0 : load_pos_reg;
                ll = complete_reg ? '0 : load_len_reg;
                wf = complete_reg ? 1'b1 : well_formed_reg;
                if (complete_reg) begin
                    overflow_reg <= 1'b0;
                    rp_reg <= '0;
                    epos_reg <= '0;
                    elen_reg <= '0;
                    eins_reg <= 1'b0;
                end
                complete_reg <= job.in_last;
                if (lc >= CW'(BUFFER_BYTES)) begin
                    overflow_reg <= 1'b1;
                    wf = 1'b0;
                end else begin
                    if (wf) begin
                        if (lp == 16'(LENGTH_FIELD_OFFSET + 1)) begin
                            ll = 17'(PRIMARY_HEADER_BYTES)
                                 + {1'b0, prev_byte_reg, job.in_byte} + 17'd1;
                        end
                        lp = lp + 16'd1;
                        if (lp >= 16'(PRIMARY_HEADER_BYTES) && {1'b0, lp} == ll) begin
                            lp = 16'd0;
                        end
                    end
                    prev_byte_reg <= job.in_byte;
                    lc = lc + CW'(1);
                end
                if (job.in_last) begin
                    if (lp != 16'd0) begin
                        wf = 1'b0;
                    end
                    secs_reg <= job.time_seconds;
                    subs_reg <= job.subseconds;
                end
                load_count_reg <= lc;
                load_pos_reg <= lp;
                load_len_reg <= ll;
                well_formed_reg <= wf;
            end
            if (fetch_go) begin
                if (have_byte) begin
                    ph2_reg <= 1'b1;
                    lo_phase_reg <= 1'b0;
                end else begin
                    out_reg <= '{8'd0, 1'b0, 1'b0, !well_formed_reg, overflow_reg};
                end
            end
            if (ph2_reg) begin
                if (lo_step) begin
                    lo_phase_reg <= 1'b1;
                end else begin
                    logic [CW-1:0] rpn;
                    ph2_reg <= 1'b0;
                    if (!well_formed_reg) begin
                        rpn = rp_reg + CW'(1);
                        out_reg <= '{rd_reg, 1'b1, rpn >= load_count_reg, 1'b1, overflow_reg};
                    end else begin
                        rpn = adv ? rp_reg + CW'(1) : rp_reg;
                        out_reg <= '{ob, 1'b1, rpn >= load_count_reg, 1'b0, overflow_reg};
                        epos_reg <= p_n;
                        if (epos_reg == 17'd0) begin
                            eins_reg <= ins_f;
                        end
                        if (epos_reg == 17'(LENGTH_FIELD_OFFSET)) begin
                            elen_reg <= 17'(PRIMARY_HEADER_BYTES)
                                        + {1'b0, rd_reg, lo_reg} + 17'd1;
                            hi_reg <= rd_reg;
                        end
                    end
                    rp_reg <= rpn;
                end
            end
        end
    end

    a_no_fetch_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ph2_reg |-> !job_ready)
        else $error("job accepted during fetch");
    a_rp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rp_reg <= load_count_reg)
        else $error("read pointer beyond load count");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        outv_reg && !out_ch.ready |=> outv_reg && $stable(out_reg))
        else $error("result changed while stalled");
endmodule
